@@ rtl/upd_pkg.sv @@
// upd_pkg: shared types, character codes and hex helpers for the url percent decoder
// no dependencies
`default_nettype none

package upd_pkg;

   // character codes
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_MINUS   = 8'h2D;

   // escape phase codes
   localparam logic [1:0] PH_IDLE  = 2'd0;
   localparam logic [1:0] PH_PCT   = 2'd1;
   localparam logic [1:0] PH_FIRST = 2'd2;

   // result queue sizing
   localparam int RspDepth = 4;
   localparam int RspPtrW  = $clog2(RspDepth);
   localparam int RspCntW  = $clog2(RspDepth + 1);

   // one result transaction
   typedef struct packed {
      logic       string_done;
      logic       run_last;
      logic [7:0] out_byte;
   } rsp_item_type;

   // decoder outcome for one input byte
   typedef struct packed {
      logic [1:0]   count;
      rsp_item_type res0;
      rsp_item_type res1;
      logic [1:0]   phase;
      logic         held_load;
   } dec_out_type;

   // hex digit: bit 4 is the valid flag, bits 3:0 the value
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, 4'(c - 8'h30)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r = {1'b1, 4'(c - 8'h41 + 8'd10)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r = {1'b1, 4'(c - 8'h61 + 8'd10)};
      end
      return r;
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return (c == CH_SPACE) || (c >= 8'h09 && c <= 8'h0D);
   endfunction

   function automatic logic [7:0] plain_byte(input logic [7:0] c);
      return (c == CH_PLUS) ? CH_SPACE : c;
   endfunction

endpackage

`default_nettype wire

@@ rtl/upd_decode.sv @@
// upd_decode: combinational escape decoder for one byte against the current phase
// depends on upd_pkg
`default_nettype none

module upd_decode
   import upd_pkg::*;
(
   input  wire logic [1:0] phase,
   input  wire logic [7:0] held_digit,
   input  wire logic [7:0] in_byte,
   input  wire logic       end_of_string,
   output dec_out_type     dec
);

   logic [4:0] ha;
   logic [4:0] hb;
   logic [7:0] pair;

   // value of a two byte escape, read as base 16, with sign and single digit fallbacks
   always_comb begin
      ha = hex_digit(held_digit);
      hb = hex_digit(in_byte);
      if (ha[4]) begin
         pair = hb[4] ? {ha[3:0], hb[3:0]} : {4'd0, ha[3:0]};
      end else if (!hb[4]) begin
         pair = 8'd0;
      end else if (is_space(held_digit) || held_digit == CH_PLUS) begin
         pair = {4'd0, hb[3:0]};
      end else if (held_digit == CH_MINUS) begin
         pair = 8'(8'd0 - {4'd0, hb[3:0]});
      end else begin
         pair = 8'd0;
      end
   end

   // phase step and results
   always_comb begin
      dec           = '0;
      dec.phase     = PH_IDLE;
      dec.res0      = '{string_done: end_of_string, run_last: 1'b1,
                        out_byte: plain_byte(in_byte)};
      dec.res1      = '{string_done: 1'b1, run_last: 1'b1,
                        out_byte: plain_byte(in_byte)};
      dec.count     = 2'd1;
      case (phase)
         PH_FIRST: begin
            dec.res0.out_byte = pair;
         end
         PH_PCT: begin
            if (!end_of_string) begin
               dec.count     = 2'd0;
               dec.held_load = 1'b1;
               dec.phase     = PH_FIRST;
            end else begin
               dec.res0  = '{string_done: 1'b0, run_last: 1'b0, out_byte: CH_PERCENT};
               dec.count = 2'd2;
            end
         end
         default: begin
            if (in_byte == CH_PERCENT && !end_of_string) begin
               dec.count = 2'd0;
               dec.phase = PH_PCT;
            end
         end
      endcase
   end

endmodule

`default_nettype wire

@@ rtl/upd_rsp_fifo.sv @@
// upd_rsp_fifo: small result queue taking up to two results per cycle, giving one
// depends on upd_pkg
`default_nettype none

module upd_rsp_fifo
   import upd_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic [1:0]   push_count,
   input  wire rsp_item_type push0,
   input  wire rsp_item_type push1,
   output logic              room_two,
   output logic              head_valid,
   output rsp_item_type      head,
   input  wire logic         head_ready
);

   rsp_item_type             mem [RspDepth];
   logic [RspPtrW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [RspPtrW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [RspCntW-1:0]       count_ff, count_in;
   logic [RspCntW-1:0]       count_after_pop;
   logic                     pop;
   logic [RspPtrW-1:0]       wr_ptr_next;

   assign head_valid  = (count_ff != '0);
   assign head        = mem[rd_ptr_ff];
   assign pop         = head_valid && head_ready;
   assign wr_ptr_next = wr_ptr_ff + RspPtrW'(1);

   // space check for a two result transaction
   assign count_after_pop = count_ff - RspCntW'(pop);
   assign room_two        = (count_after_pop <= RspCntW'(RspDepth - 2));

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff + RspPtrW'(push_count);
      rd_ptr_in = rd_ptr_ff + RspPtrW'(pop);
      count_in  = count_after_pop + RspCntW'(push_count);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage writes
   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         mem[wr_ptr_ff] <= push0;
      end
      if (push_count == 2'd2) begin
         mem[wr_ptr_next] <= push1;
      end
   end

endmodule

`default_nettype wire

@@ rtl/url_percent_decoder.sv @@
// url_percent_decoder: streaming percent decoder, top level
// depends on upd_pkg, upd_decode, upd_rsp_fifo
//
//   channel | direction | tdata          | tlast         | tuser
//   req     | in        | [7:0] in_byte  | end_of_string | -
//   rsp     | out       | [7:0] out_byte | string_done   | run_last
//
// one byte per cycle while the result queue has room for two; two results are queued at once
// an accepted byte passes through the input register and then the result queue
// the result queue holds four entries so input keeps flowing while rsp stalls, until it fills
// synchronous active high reset clears phase, held digit, input valid and queue
`default_nettype none

module url_percent_decoder
   import upd_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] in_byte
   input  wire logic       req_tlast,   // end_of_string
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,   // [7:0] out_byte
   output logic            rsp_tlast,   // string_done
   output logic            rsp_tuser    // [0] run_last
);

   logic         in_vld_ff, in_vld_in;
   logic [7:0]   in_byte_ff;
   logic         in_end_ff;
   logic [1:0]   phase_ff, phase_in;
   logic [7:0]   held_ff, held_in;
   logic         room_two;
   logic         take;
   logic [1:0]   push_count;
   dec_out_type  dec;
   rsp_item_type head;

   // move the registered byte into the decoder when the queue has room for two results
   assign take       = in_vld_ff && room_two;
   assign req_tready = !in_vld_ff || take;
   assign push_count = take ? dec.count : 2'd0;

   always_comb begin
      in_vld_in = in_vld_ff;
      if (req_tready) begin
         in_vld_in = req_tvalid;
      end
      phase_in = phase_ff;
      held_in  = held_ff;
      if (take) begin
         phase_in = dec.phase;
         if (dec.held_load) begin
            held_in = in_byte_ff;
         end
      end
   end

   // input valid, phase and held digit registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
         phase_ff  <= PH_IDLE;
         held_ff   <= 8'd0;
      end else begin
         in_vld_ff <= in_vld_in;
         phase_ff  <= phase_in;
         held_ff   <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_end_ff  <= req_tlast;
      end
   end

   upd_decode u_decode (
      .phase         (phase_ff),
      .held_digit    (held_ff),
      .in_byte       (in_byte_ff),
      .end_of_string (in_end_ff),
      .dec           (dec)
   );

   upd_rsp_fifo u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_count (push_count),
      .push0      (dec.res0),
      .push1      (dec.res1),
      .room_two   (room_two),
      .head_valid (rsp_tvalid),
      .head       (head),
      .head_ready (rsp_tready)
   );

   // result channel
   assign rsp_tdata = head.out_byte;
   assign rsp_tlast = head.string_done;
   assign rsp_tuser = head.run_last;

endmodule

`default_nettype wire
